// ----- design/rpm_pkg.sv -----
// types, codes and saturation helpers for the reference path matcher
// no dependencies; imported by reference_path_matcher
package rpm_pkg;

    // request kinds
    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_POS    = 2'd2,
        KIND_ARC    = 2'd3
    } kind_t;

    // response status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // one stored path point
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] h;
        logic signed [31:0] k;
        logic signed [31:0] dk;
        logic signed [31:0] ddk;
        logic signed [31:0] s;
    } pt_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SEG,
        ST_BS_RD,
        ST_BS_CMP,
        ST_BS_END,
        ST_RD0,
        ST_RD1,
        ST_CAP1,
        ST_PREP,
        ST_PMUL,
        ST_SQRT,
        ST_PDIV,
        ST_PFIN,
        ST_IPREP,
        ST_LMUL,
        ST_LDIV,
        ST_LFIN,
        ST_DONE
    } state_t;

    // interpolated fields, in processing order
    localparam logic [2:0] FLD_X   = 3'd0;
    localparam logic [2:0] FLD_Y   = 3'd1;
    localparam logic [2:0] FLD_K   = 3'd2;
    localparam logic [2:0] FLD_DK  = 3'd3;
    localparam logic [2:0] FLD_DDK = 3'd4;

    // iteration counts of the shared units
    localparam logic [6:0] SQRT_STEPS    = 7'd33;
    localparam logic [6:0] DIV_POS_BITS  = 7'd63;
    localparam logic [6:0] DIV_LERP_BITS = 7'd35;
    localparam logic [2:0] PMUL_LAST     = 3'd4;
    localparam logic [2:0] LMUL_LAST     = 3'd2;

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // saturate a 37-bit signed value to 32 bits
    function automatic logic signed [31:0] sat37(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647)
            r = S32_MAX;
        else if (v < -37'sd2147483648)
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = S32_MAX;
        else if (v < -64'sd2147483648)
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- design/reference_path_matcher.sv -----
// reference path matcher: point table in one memory, scan and search sequencer,
// shared multiplier, square root and divider; depends on rpm_pkg
//
//  channel  handshake             payload
//  request  req_valid/req_stall   kind, pos_x, pos_y, heading, curvature,
//                                 curvature_rate, curvature_accel, arc_length
//  response rsp_valid/rsp_stall   status, out_x, out_y, out_heading, out_curvature,
//                                 out_curvature_rate, out_curvature_accel, out_arc_length
//
// one request at a time; clear, append and empty queries go from EXEC straight to DONE
// position query: run time for n stored points set by the one-read-per-cycle
// scan of the table, the 33-step square root, the 63-step divide and five lerps
// arc query: run time set by the lerps and the search reads
// reset empties the table through the point count only; the memory is not cleared
// a finished response waits in the output register while the next request is taken
module reference_path_matcher #(
    parameter int MAX_POINTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         kind,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] heading,
    input  logic signed [31:0] curvature,
    input  logic signed [31:0] curvature_rate,
    input  logic signed [31:0] curvature_accel,
    input  logic signed [31:0] arc_length,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [1:0]         status,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [15:0] out_heading,
    output logic signed [31:0] out_curvature,
    output logic signed [31:0] out_curvature_rate,
    output logic signed [31:0] out_curvature_accel,
    output logic signed [31:0] out_arc_length
);
    import rpm_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // point memory
    pt_t           mem [MAX_POINTS];
    pt_t           mem_rdata_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    // control registers
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic          p1v_reg, p1v_next;
    logic          p2v_reg, p2v_next;
    logic          p3v_reg, p3v_next;

    // payload registers
    kind_t              req_kind_reg, req_kind_next;
    pt_t                req_pt_reg, req_pt_next;
    logic [CW-1:0]      iss_reg, iss_next;
    logic [AW-1:0]      p1idx_reg, p1idx_next;
    logic [AW-1:0]      p2idx_reg, p2idx_next;
    logic [AW-1:0]      p3idx_reg, p3idx_next;
    logic [31:0]        ax_reg, ax_next;
    logic [31:0]        ay_reg, ay_next;
    logic [63:0]        sx_reg, sx_next;
    logic [63:0]        sy_reg, sy_next;
    logic [AW-1:0]      best_reg, best_next;
    logic [64:0]        bestd_reg, bestd_next;
    logic [CW-1:0]      first_reg, first_next;
    logic [CW-1:0]      bcnt_reg, bcnt_next;
    logic [AW-1:0]      lo_reg, lo_next;
    logic [AW-1:0]      hi_reg, hi_next;
    pt_t                p0_reg, p0_next;
    pt_t                p1_reg, p1_next;
    logic signed [32:0] v0x_reg, v0x_next;
    logic signed [32:0] v0y_reg, v0y_next;
    logic signed [32:0] v1x_reg, v1x_next;
    logic signed [32:0] v1y_reg, v1y_next;
    logic [2:0]         mcnt_reg, mcnt_next;
    logic signed [65:0] mul_reg, mul_next;
    logic [65:0]        rad_reg, rad_next;
    logic signed [66:0] dot_reg, dot_next;
    logic [65:0]        sq_sh_reg, sq_sh_next;
    logic [34:0]        sq_rem_reg, sq_rem_next;
    logic [32:0]        sq_root_reg, sq_root_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [95:0]        dv_sh_reg, dv_sh_next;
    logic [32:0]        dv_rem_reg, dv_rem_next;
    logic [62:0]        dv_q_reg, dv_q_next;
    logic [32:0]        dv_den_reg, dv_den_next;
    logic               dv_ovf_reg, dv_ovf_next;
    logic signed [63:0] num_reg, num_next;
    logic signed [32:0] den_reg, den_next;
    logic signed [63:0] s_reg, s_next;
    logic [2:0]         fld_reg, fld_next;
    logic [95:0]        prod_reg, prod_next;
    pt_t                res_reg, res_next;
    logic [1:0]         res_status_reg, res_status_next;
    pt_t                rsp_pt_reg, rsp_pt_next;
    logic [1:0]         rsp_status_reg, rsp_status_next;

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;

    // scan distance terms
    logic signed [32:0] scan_dx, scan_dy;
    logic [32:0]        scan_dx_neg, scan_dy_neg;
    logic [64:0]        scan_d;
    logic               scan_done;

    // search and segment helpers
    logic [CW-1:0]      bs_step, bs_it;
    logic [CW-1:0]      best_inc;
    logic               v1_zero;
    logic signed [32:0] pv1x, pv1y;

    // lerp helpers
    logic signed [31:0] lerp_a, lerp_b;
    logic signed [32:0] ldiff;
    logic [32:0]        ldiff_neg;
    logic [31:0]        lmag;
    logic [63:0]        num_neg;
    logic [63:0]        nmag;
    logic [32:0]        den_neg;
    logic [32:0]        dmag;
    logic               lneg;
    logic [95:0]        lprod;
    logic signed [36:0] lext, lval;
    logic signed [31:0] lres;
    logic signed [16:0] hsum;

    // iteration helpers
    logic [36:0]        sq_r2, sq_trial, sq_diff;
    logic               sq_ge;
    logic [33:0]        dv_t, dv_sub;
    logic               dv_ge;
    logic signed [66:0] dot_fin;
    logic [66:0]        dabs;
    logic [62:0]        ds63;
    logic signed [63:0] dsig;

    assign req_stall           = (state_reg != ST_IDLE);
    assign rsp_valid           = rsp_valid_reg;
    assign status              = rsp_status_reg;
    assign out_x               = rsp_pt_reg.x;
    assign out_y               = rsp_pt_reg.y;
    assign out_heading         = rsp_pt_reg.h;
    assign out_curvature       = rsp_pt_reg.k;
    assign out_curvature_rate  = rsp_pt_reg.dk;
    assign out_curvature_accel = rsp_pt_reg.ddk;
    assign out_arc_length      = rsp_pt_reg.s;

    // scan distance from the point just read
    assign scan_dx     = {mem_rdata_reg.x[31], mem_rdata_reg.x} - {req_pt_reg.x[31], req_pt_reg.x};
    assign scan_dy     = {mem_rdata_reg.y[31], mem_rdata_reg.y} - {req_pt_reg.y[31], req_pt_reg.y};
    assign scan_dx_neg = -scan_dx;
    assign scan_dy_neg = -scan_dy;
    assign scan_d      = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign scan_done   = (iss_reg == count_reg) && !p1v_reg && !p2v_reg && !p3v_reg;

    // search probe and neighbor index
    assign bs_step  = bcnt_reg >> 1;
    assign bs_it    = first_reg + bs_step;
    assign best_inc = CW'(best_reg) + CW'(1);

    // segment vector check
    assign pv1x    = {p1_reg.x[31], p1_reg.x} - {p0_reg.x[31], p0_reg.x};
    assign pv1y    = {p1_reg.y[31], p1_reg.y} - {p0_reg.y[31], p0_reg.y};
    assign v1_zero = (pv1x == 33'sd0) && (pv1y == 33'sd0);

    // lerp operands for the current field
    always_comb
    begin
        case (fld_reg)
            FLD_X:
            begin
                lerp_a = p0_reg.x;
                lerp_b = p1_reg.x;
            end
            FLD_Y:
            begin
                lerp_a = p0_reg.y;
                lerp_b = p1_reg.y;
            end
            FLD_K:
            begin
                lerp_a = p0_reg.k;
                lerp_b = p1_reg.k;
            end
            FLD_DK:
            begin
                lerp_a = p0_reg.dk;
                lerp_b = p1_reg.dk;
            end
            default:
            begin
                lerp_a = p0_reg.ddk;
                lerp_b = p1_reg.ddk;
            end
        endcase
    end

    // lerp magnitudes and sign
    assign ldiff     = {lerp_b[31], lerp_b} - {lerp_a[31], lerp_a};
    assign ldiff_neg = -ldiff;
    assign lmag      = ldiff[32] ? ldiff_neg[31:0] : ldiff[31:0];
    assign num_neg   = -num_reg;
    assign nmag      = num_reg[63] ? num_neg : num_reg;
    assign den_neg   = -den_reg;
    assign dmag      = den_reg[32] ? den_neg : den_reg;
    assign lneg      = ldiff[32] ^ num_reg[63] ^ den_reg[32];
    assign lprod     = prod_reg + {mul_reg[63:0], 32'd0};
    assign lext      = {{5{lerp_a[31]}}, lerp_a};
    assign lval      = lneg ? (lext - $signed({2'b00, dv_q_reg[34:0]}))
                            : (lext + $signed({2'b00, dv_q_reg[34:0]}));
    assign lres      = dv_ovf_reg ? (lneg ? S32_MIN : S32_MAX) : sat37(lval);
    assign hsum      = {p0_reg.h[15], p0_reg.h} + {p1_reg.h[15], p1_reg.h};

    // square root step, two radicand bits at a time
    assign sq_r2    = {sq_rem_reg, sq_sh_reg[65:64]};
    assign sq_trial = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge    = (sq_r2 >= sq_trial);
    assign sq_diff  = sq_r2 - sq_trial;

    // restoring divide step
    assign dv_t   = {dv_rem_reg, dv_sh_reg[95]};
    assign dv_ge  = (dv_t >= {1'b0, dv_den_reg});
    assign dv_sub = dv_t - {1'b0, dv_den_reg};

    // projection offset
    assign dot_fin = dot_reg + 67'(mul_reg);
    assign dabs    = dot_reg[66] ? 67'(-dot_reg) : 67'(dot_reg);
    assign ds63    = dv_ovf_reg ? {63{1'b1}} : dv_q_reg;
    assign dsig    = dot_reg[66] ? -$signed({1'b0, ds63}) : $signed({1'b0, ds63});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (req_kind_reg == KIND_CLEAR || req_kind_reg == KIND_APPEND)
                    state_next = ST_DONE;
                else if (count_reg == CW'(0))
                    state_next = ST_DONE;
                else if (req_kind_reg == KIND_POS)
                    state_next = ST_SCAN;
                else
                    state_next = ST_BS_RD;
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_SEG;
            end
            ST_SEG:
                state_next = ST_RD0;
            ST_BS_RD:
            begin
                if (bcnt_reg != CW'(0))
                    state_next = ST_BS_CMP;
                else
                    state_next = ST_BS_END;
            end
            ST_BS_CMP:
                state_next = ST_BS_RD;
            ST_BS_END:
                state_next = ST_RD0;
            ST_RD0:
                state_next = ST_RD1;
            ST_RD1:
                state_next = ST_CAP1;
            ST_CAP1:
                state_next = ST_PREP;
            ST_PREP:
            begin
                if (lo_reg == hi_reg)
                    state_next = ST_DONE;
                else if (req_kind_reg == KIND_POS)
                    state_next = v1_zero ? ST_DONE : ST_PMUL;
                else
                    state_next = ST_IPREP;
            end
            ST_PMUL:
            begin
                if (mcnt_reg == PMUL_LAST)
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (cnt_reg == 7'd0)
                    state_next = ST_PDIV;
            end
            ST_PDIV:
            begin
                if (cnt_reg == 7'd0)
                    state_next = ST_PFIN;
            end
            ST_PFIN:
                state_next = ST_IPREP;
            ST_IPREP:
            begin
                if (den_reg == 33'sd0)
                    state_next = ST_DONE;
                else
                    state_next = ST_LMUL;
            end
            ST_LMUL:
            begin
                if (mcnt_reg == LMUL_LAST)
                    state_next = ST_LDIV;
            end
            ST_LDIV:
            begin
                if (cnt_reg == 7'd0)
                    state_next = ST_LFIN;
            end
            ST_LFIN:
            begin
                if (fld_reg == FLD_DDK)
                    state_next = ST_DONE;
                else
                    state_next = ST_LMUL;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg;
        p1v_next        = 1'b0;
        p2v_next        = 1'b0;
        p3v_next        = 1'b0;
        req_kind_next   = req_kind_reg;
        req_pt_next     = req_pt_reg;
        iss_next        = iss_reg;
        p1idx_next      = p1idx_reg;
        p2idx_next      = p2idx_reg;
        p3idx_next      = p3idx_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        best_next       = best_reg;
        bestd_next      = bestd_reg;
        first_next      = first_reg;
        bcnt_next       = bcnt_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        p0_next         = p0_reg;
        p1_next         = p1_reg;
        v0x_next        = v0x_reg;
        v0y_next        = v0y_reg;
        v1x_next        = v1x_reg;
        v1y_next        = v1y_reg;
        mcnt_next       = mcnt_reg;
        rad_next        = rad_reg;
        dot_next        = dot_reg;
        sq_sh_next      = sq_sh_reg;
        sq_rem_next     = sq_rem_reg;
        sq_root_next    = sq_root_reg;
        cnt_next        = cnt_reg;
        dv_sh_next      = dv_sh_reg;
        dv_rem_next     = dv_rem_reg;
        dv_q_next       = dv_q_reg;
        dv_den_next     = dv_den_reg;
        dv_ovf_next     = dv_ovf_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        s_next          = s_reg;
        fld_next        = fld_reg;
        prod_next       = prod_reg;
        res_next        = res_reg;
        res_status_next = res_status_reg;
        rsp_pt_next     = rsp_pt_reg;
        rsp_status_next = rsp_status_reg;

        // response register drains independently
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_kind_next = kind_t'(kind);
                    req_pt_next   = '{x: pos_x, y: pos_y, h: heading, k: curvature,
                                      dk: curvature_rate, ddk: curvature_accel,
                                      s: arc_length};
                end
            end
            ST_EXEC:
            begin
                res_next        = '0;
                res_status_next = STATUS_OK;
                iss_next        = '0;
                first_next      = '0;
                bcnt_next       = count_reg;
                case (req_kind_reg)
                    KIND_CLEAR:
                        count_next = '0;
                    KIND_APPEND:
                    begin
                        if (count_reg >= CW'(MAX_POINTS))
                            res_status_next = STATUS_FULL;
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    default:
                    begin
                        if (count_reg == CW'(0))
                            res_status_next = STATUS_EMPTY;
                    end
                endcase
            end
            ST_SCAN:
            begin
                // stage 0: issue a read
                if (iss_reg != count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = iss_reg[AW-1:0];
                    iss_next   = iss_reg + CW'(1);
                    p1v_next   = 1'b1;
                    p1idx_next = iss_reg[AW-1:0];
                end
                // stage 1: absolute offsets
                p2v_next = p1v_reg;
                if (p1v_reg)
                begin
                    ax_next    = scan_dx[32] ? scan_dx_neg[31:0] : scan_dx[31:0];
                    ay_next    = scan_dy[32] ? scan_dy_neg[31:0] : scan_dy[31:0];
                    p2idx_next = p1idx_reg;
                end
                // stage 2: squares
                p3v_next = p2v_reg;
                if (p2v_reg)
                begin
                    sx_next    = ax_reg * ax_reg;
                    sy_next    = ay_reg * ay_reg;
                    p3idx_next = p2idx_reg;
                end
                // stage 3: keep the first nearest
                if (p3v_reg && (p3idx_reg == AW'(0) || scan_d < bestd_reg))
                begin
                    best_next  = p3idx_reg;
                    bestd_next = scan_d;
                end
            end
            ST_SEG:
            begin
                lo_next = (best_reg == AW'(0)) ? AW'(0) : best_reg - AW'(1);
                hi_next = (best_inc == count_reg) ? best_reg : best_inc[AW-1:0];
            end
            ST_BS_RD:
            begin
                if (bcnt_reg != CW'(0))
                begin
                    rd_en   = 1'b1;
                    rd_addr = bs_it[AW-1:0];
                end
            end
            ST_BS_CMP:
            begin
                if (mem_rdata_reg.s < req_pt_reg.s)
                begin
                    first_next = bs_it + CW'(1);
                    bcnt_next  = bcnt_reg - bs_step - CW'(1);
                end
                else
                    bcnt_next = bs_step;
            end
            ST_BS_END:
            begin
                if (first_reg == CW'(0))
                begin
                    lo_next = '0;
                    hi_next = '0;
                end
                else if (first_reg >= count_reg)
                begin
                    lo_next = AW'(count_reg - CW'(1));
                    hi_next = AW'(count_reg - CW'(1));
                end
                else
                begin
                    lo_next = AW'(first_reg - CW'(1));
                    hi_next = first_reg[AW-1:0];
                end
            end
            ST_RD0:
            begin
                rd_en   = 1'b1;
                rd_addr = lo_reg;
            end
            ST_RD1:
            begin
                rd_en   = 1'b1;
                rd_addr = hi_reg;
                p0_next = mem_rdata_reg;
            end
            ST_CAP1:
                p1_next = mem_rdata_reg;
            ST_PREP:
            begin
                v1x_next  = pv1x;
                v1y_next  = pv1y;
                v0x_next  = {req_pt_reg.x[31], req_pt_reg.x} - {p0_reg.x[31], p0_reg.x};
                v0y_next  = {req_pt_reg.y[31], req_pt_reg.y} - {p0_reg.y[31], p0_reg.y};
                mcnt_next = '0;
                num_next  = 64'(req_pt_reg.s) - 64'(p0_reg.s);
                s_next    = 64'(req_pt_reg.s);
                den_next  = {p1_reg.s[31], p1_reg.s} - {p0_reg.s[31], p0_reg.s};
                if (lo_reg == hi_reg || (req_kind_reg == KIND_POS && v1_zero))
                    res_next = p0_reg;
            end
            ST_PMUL:
            begin
                case (mcnt_reg)
                    3'd0:
                    begin
                        mul_a = v1x_reg;
                        mul_b = v1x_reg;
                    end
                    3'd1:
                    begin
                        mul_a = v1y_reg;
                        mul_b = v1y_reg;
                    end
                    3'd2:
                    begin
                        mul_a = v0x_reg;
                        mul_b = v1x_reg;
                    end
                    3'd3:
                    begin
                        mul_a = v0y_reg;
                        mul_b = v1y_reg;
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
                case (mcnt_reg)
                    3'd1:
                        rad_next = mul_reg;
                    3'd2:
                        rad_next = rad_reg + mul_reg;
                    3'd3:
                        dot_next = 67'(mul_reg);
                    3'd4:
                        dot_next = dot_fin;
                    default:
                        rad_next = rad_reg;
                endcase
                if (mcnt_reg == PMUL_LAST)
                begin
                    sq_sh_next   = rad_reg;
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    cnt_next     = SQRT_STEPS;
                end
                else
                    mcnt_next = mcnt_reg + 3'd1;
            end
            ST_SQRT:
            begin
                if (cnt_reg != 7'd0)
                begin
                    sq_rem_next  = sq_ge ? sq_diff[34:0] : sq_r2[34:0];
                    sq_root_next = {sq_root_reg[31:0], sq_ge};
                    sq_sh_next   = {sq_sh_reg[63:0], 2'b00};
                    cnt_next     = cnt_reg - 7'd1;
                end
                else
                begin
                    // divide |dot| by the segment length
                    dv_rem_next = {29'd0, dabs[66:63]};
                    dv_ovf_next = ({29'd0, dabs[66:63]} >= sq_root_reg);
                    dv_sh_next  = {dabs[62:0], 33'd0};
                    dv_den_next = sq_root_reg;
                    dv_q_next   = '0;
                    cnt_next    = DIV_POS_BITS;
                end
            end
            ST_PDIV, ST_LDIV:
            begin
                if (cnt_reg != 7'd0)
                begin
                    dv_rem_next = dv_ge ? dv_sub[32:0] : dv_t[32:0];
                    dv_q_next   = {dv_q_reg[61:0], dv_ge};
                    dv_sh_next  = {dv_sh_reg[94:0], 1'b0};
                    cnt_next    = cnt_reg - 7'd1;
                end
            end
            ST_PFIN:
            begin
                num_next = dsig;
                s_next   = 64'(p0_reg.s) + dsig;
                den_next = {p1_reg.s[31], p1_reg.s} - {p0_reg.s[31], p0_reg.s};
            end
            ST_IPREP:
            begin
                fld_next  = FLD_X;
                mcnt_next = '0;
                if (den_reg == 33'sd0)
                    res_next = p0_reg;
            end
            ST_LMUL:
            begin
                mul_a = $signed({1'b0, lmag});
                if (mcnt_reg == 3'd0)
                    mul_b = $signed({1'b0, nmag[31:0]});
                else
                    mul_b = $signed({1'b0, nmag[63:32]});
                if (mcnt_reg == 3'd1)
                    prod_next = {32'd0, mul_reg[63:0]};
                if (mcnt_reg == LMUL_LAST)
                begin
                    // start |diff| * |num| / |den|
                    dv_rem_next = lprod[67:35];
                    dv_ovf_next = (lprod[95:35] >= {28'd0, dmag});
                    dv_sh_next  = {lprod[34:0], 61'd0};
                    dv_den_next = dmag;
                    dv_q_next   = '0;
                    cnt_next    = DIV_LERP_BITS;
                end
                else
                    mcnt_next = mcnt_reg + 3'd1;
            end
            ST_LFIN:
            begin
                case (fld_reg)
                    FLD_X:
                        res_next.x = lres;
                    FLD_Y:
                        res_next.y = lres;
                    FLD_K:
                        res_next.k = lres;
                    FLD_DK:
                        res_next.dk = lres;
                    default:
                        res_next.ddk = lres;
                endcase
                if (fld_reg == FLD_DDK)
                begin
                    res_next.h = hsum[16:1];
                    res_next.s = sat64(s_reg);
                end
                fld_next  = fld_reg + 3'd1;
                mcnt_next = '0;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_pt_next     = res_reg;
                    rsp_status_next = res_status_reg;
                end
            end
            default:
                rd_en = 1'b0;
        endcase
    end

    // shared multiplier
    assign mul_next = mul_a * mul_b;

    // point memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[AW-1:0]] <= req_pt_reg;
        if (rd_en)
            mem_rdata_reg <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            p1v_reg       <= 1'b0;
            p2v_reg       <= 1'b0;
            p3v_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            p1v_reg       <= p1v_next;
            p2v_reg       <= p2v_next;
            p3v_reg       <= p3v_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_kind_reg   <= req_kind_next;
        req_pt_reg     <= req_pt_next;
        iss_reg        <= iss_next;
        p1idx_reg      <= p1idx_next;
        p2idx_reg      <= p2idx_next;
        p3idx_reg      <= p3idx_next;
        ax_reg         <= ax_next;
        ay_reg         <= ay_next;
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        best_reg       <= best_next;
        bestd_reg      <= bestd_next;
        first_reg      <= first_next;
        bcnt_reg       <= bcnt_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        p0_reg         <= p0_next;
        p1_reg         <= p1_next;
        v0x_reg        <= v0x_next;
        v0y_reg        <= v0y_next;
        v1x_reg        <= v1x_next;
        v1y_reg        <= v1y_next;
        mcnt_reg       <= mcnt_next;
        mul_reg        <= mul_next;
        rad_reg        <= rad_next;
        dot_reg        <= dot_next;
        sq_sh_reg      <= sq_sh_next;
        sq_rem_reg     <= sq_rem_next;
        sq_root_reg    <= sq_root_next;
        cnt_reg        <= cnt_next;
        dv_sh_reg      <= dv_sh_next;
        dv_rem_reg     <= dv_rem_next;
        dv_q_reg       <= dv_q_next;
        dv_den_reg     <= dv_den_next;
        dv_ovf_reg     <= dv_ovf_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        s_reg          <= s_next;
        fld_reg        <= fld_next;
        prod_reg       <= prod_next;
        res_reg        <= res_next;
        res_status_reg <= res_status_next;
        rsp_pt_reg     <= rsp_pt_next;
        rsp_status_reg <= rsp_status_next;
    end

    // table never holds more points than it has room for
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond table depth");

    // reads and the append write never share a cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(rd_en && wr_en))
        else $error("memory read and write in the same cycle");

    // search window stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BS_CMP) |-> ((CW+1)'(first_reg) + (CW+1)'(bcnt_reg)
                                      <= (CW+1)'(count_reg)))
        else $error("search window past the last point");

    // divider remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_PDIV || state_reg == ST_LDIV) && !dv_ovf_reg)
            |-> (dv_rem_reg < dv_den_reg))
        else $error("divider remainder not below divisor");

    // scan compares only indexes that were issued
    assert property (@(posedge clk) disable iff (!rst_n)
        p3v_reg |-> (CW'(p3idx_reg) < count_reg))
        else $error("scan index beyond point count");

endmodule
